// ----- hw/rtl/scda_pkg.sv -----
`timescale 1ns / 1ps

package scda_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CFG_MAX_DELTA = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_KCAL      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_STRIDE    = 2'd2;

   localparam logic [15:0] MAX_DELTA_RESET = 16'd12;
   localparam logic [9:0]  KCAL_RESET      = 10'd40;
   localparam logic [11:0] STRIDE_RESET    = 12'd700;

   // unsigned divide by 1000: (n * MAGIC) >> SHIFT, exact for 32-bit n
   localparam logic [28:0] DIV1000_MAGIC = 29'h10624DD3;
   localparam int          DIV1000_SHIFT = 38;
   localparam logic [9:0]  THOUSAND      = 10'd1000;
   localparam logic [8:0]  ROUND_HALF    = 9'd500;

   // day key validity limits
   localparam logic [3:0] MONTH_MIN = 4'd1;
   localparam logic [3:0] MONTH_MAX = 4'd12;

   typedef struct packed {
      logic [15:0] max_delta;
      logic [9:0]  kcal;
      logic [11:0] stride;
   } cfg_type;

   typedef struct packed {
      logic [15:0] count;
      logic        date_ok;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
   } poll_type;

   typedef struct packed {
      logic        publish;
      logic        metrics_valid;
      logic [31:0] total;
   } tally_type;

endpackage

// ----- hw/rtl/scda_csr.sv -----
`timescale 1ns / 1ps

module scda_csr
   import scda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CFG_MAX_DELTA: cfg_in.max_delta = csr_write_data;
            CFG_KCAL:      cfg_in.kcal      = csr_write_data[9:0];
            CFG_STRIDE:    cfg_in.stride    = csr_write_data[11:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_delta <= MAX_DELTA_RESET;
         cfg_ff.kcal      <= KCAL_RESET;
         cfg_ff.stride    <= STRIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/scda_update.sv -----
`timescale 1ns / 1ps

module scda_update
   import scda_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  poll_type  in_poll,
   output logic      in_ready,
   output logic      out_valid,
   output tally_type out_tally,
   input  logic      out_ready
);

   logic        baseline_ff, baseline_in;
   logic [15:0] last_count_ff, last_count_in;
   logic [15:0] day_key_ff, day_key_in;
   logic        day_known_ff, day_known_in;
   logic [31:0] total_ff, total_in;
   logic        tally_v_ff;
   tally_type   tally_ff, tally_in;

   logic        fire;
   logic        key_valid;
   logic [15:0] key;
   logic [15:0] delta;
   logic [32:0] sum;

   assign in_ready = !tally_v_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // day key from the date
   assign key_valid = in_poll.date_ok && (in_poll.month >= MONTH_MIN)
                      && (in_poll.month <= MONTH_MAX) && (in_poll.day != 5'd0);
   assign key   = {in_poll.year, in_poll.month, in_poll.day};
   assign delta = in_poll.count - last_count_ff;
   assign sum   = {1'b0, total_ff} + {17'd0, delta};

   // baseline, new day or wrapped delta accumulation
   always_comb begin
      baseline_in   = baseline_ff;
      last_count_in = last_count_ff;
      day_key_in    = day_key_ff;
      day_known_in  = day_known_ff;
      total_in      = total_ff;
      tally_in      = tally_ff;
      if (fire) begin
         tally_in.publish = 1'b0;
         last_count_in    = in_poll.count;
         if (!baseline_ff) begin
            baseline_in      = 1'b1;
            day_known_in     = key_valid;
            day_key_in       = key_valid ? key : 16'd0;
            tally_in.publish = 1'b1;
         end else if (key_valid && (!day_known_ff || (key != day_key_ff))) begin
            day_key_in       = key;
            day_known_in     = 1'b1;
            total_in         = 32'd0;
            tally_in.publish = 1'b1;
         end else if ((delta != 16'd0) && (delta <= cfg.max_delta)) begin
            total_in         = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            tally_in.publish = 1'b1;
         end
         tally_in.metrics_valid = 1'b1;
         tally_in.total         = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= 1'b0;
         last_count_ff <= 16'd0;
         day_key_ff    <= 16'd0;
         day_known_ff  <= 1'b0;
         total_ff      <= 32'd0;
         tally_v_ff    <= 1'b0;
      end else begin
         baseline_ff   <= baseline_in;
         last_count_ff <= last_count_in;
         day_key_ff    <= day_key_in;
         day_known_ff  <= day_known_in;
         total_ff      <= total_in;
         if (in_ready) begin
            tally_v_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      tally_ff <= tally_in;
   end

   assign out_valid = tally_v_ff;
   assign out_tally = tally_ff;

   // once a baseline is taken it stays until reset
   a_baseline_sticky: assert property (@(posedge clock) disable iff (reset)
      baseline_ff |=> baseline_ff)
      else $error("baseline flag dropped");

   // a known day implies a baseline
   a_day_needs_base: assert property (@(posedge clock) disable iff (reset)
      day_known_ff |-> baseline_ff)
      else $error("day known without baseline");

   // every request leaving this stage reports a baseline
   a_tally_valid: assert property (@(posedge clock) disable iff (reset)
      tally_v_ff |-> (tally_ff.metrics_valid && baseline_ff))
      else $error("tally without baseline");

endmodule

// ----- hw/rtl/scda_metrics.sv -----
`timescale 1ns / 1ps

module scda_metrics
   import scda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  tally_type   in_tally,
   output logic        in_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_publish,
   output logic [31:0] rsp_daily_steps,
   output logic [15:0] rsp_calories,
   output logic [31:0] rsp_distance,
   output logic        rsp_metrics_valid
);

   logic v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy2, rdy3, rdy4, rdy5;

   // stage 2: thousands of steps by reciprocal
   logic [60:0] quot_prod;
   tally_type   t2_ff;
   logic [22:0] thou2_ff, thou2_in;

   // stage 3: remainder and whole-thousand products
   logic [32:0] thou_x1000;
   logic [31:0] rem_full;
   tally_type   t3_ff;
   logic [9:0]  rem3_ff, rem3_in;
   logic [32:0] kc3_ff, kc3_in;
   logic [34:0] st3_ff, st3_in;

   // stage 4: remainder products with rounding
   tally_type   t4_ff;
   logic [32:0] kc4_ff;
   logic [34:0] st4_ff;
   logic [19:0] rk4_ff, rk4_in;
   logic [21:0] rs4_ff, rs4_in;

   // stage 5: final divide, sum and saturation
   logic [48:0] qk_prod;
   logic [50:0] qs_prod;
   logic [33:0] cal_sum;
   logic [35:0] dist_sum;
   logic        pub5_ff, mv5_ff;
   logic [31:0] steps5_ff;
   logic [15:0] cal5_ff, cal5_in;
   logic [31:0] dist5_ff, dist5_in;

   // back-pressure chain
   assign rdy5     = !v5_ff || !rsp_stall;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   assign quot_prod = 61'(in_tally.total) * 61'(DIV1000_MAGIC);
   assign thou2_in  = quot_prod[DIV1000_SHIFT +: 23];

   assign thou_x1000 = 33'(thou2_ff) * 33'(THOUSAND);
   assign rem_full   = t2_ff.total - thou_x1000[31:0];
   assign rem3_in    = rem_full[9:0];
   assign kc3_in     = 33'(thou2_ff) * 33'(cfg.kcal);
   assign st3_in     = 35'(thou2_ff) * 35'(cfg.stride);

   assign rk4_in = 20'(rem3_ff) * 20'(cfg.kcal) + 20'(ROUND_HALF);
   assign rs4_in = 22'(rem3_ff) * 22'(cfg.stride) + 22'(ROUND_HALF);

   assign qk_prod  = 49'(rk4_ff) * 49'(DIV1000_MAGIC);
   assign qs_prod  = 51'(rs4_ff) * 51'(DIV1000_MAGIC);
   assign cal_sum  = 34'(kc4_ff) + 34'(qk_prod[DIV1000_SHIFT +: 10]);
   assign dist_sum = 36'(st4_ff) + 36'(qs_prod[DIV1000_SHIFT +: 12]);
   assign cal5_in  = (cal_sum > 34'h0_0000_FFFF) ? 16'hFFFF : cal_sum[15:0];
   assign dist5_in = (dist_sum > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : dist_sum[31:0];

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         t2_ff    <= in_tally;
         thou2_ff <= thou2_in;
      end
      if (rdy3 && v2_ff) begin
         t3_ff   <= t2_ff;
         rem3_ff <= rem3_in;
         kc3_ff  <= kc3_in;
         st3_ff  <= st3_in;
      end
      if (rdy4 && v3_ff) begin
         t4_ff  <= t3_ff;
         kc4_ff <= kc3_ff;
         st4_ff <= st3_ff;
         rk4_ff <= rk4_in;
         rs4_ff <= rs4_in;
      end
      if (rdy5 && v4_ff) begin
         pub5_ff   <= t4_ff.publish;
         mv5_ff    <= t4_ff.metrics_valid;
         steps5_ff <= t4_ff.total;
         cal5_ff   <= cal5_in;
         dist5_ff  <= dist5_in;
      end
   end

   assign rsp_valid         = v5_ff;
   assign rsp_publish       = pub5_ff;
   assign rsp_daily_steps   = steps5_ff;
   assign rsp_calories      = cal5_ff;
   assign rsp_distance      = dist5_ff;
   assign rsp_metrics_valid = mv5_ff;

   // reciprocal quotient never overshoots the total
   a_quot_low: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (thou_x1000 <= {1'b0, t2_ff.total}))
      else $error("thousands quotient too large");

   // remainder after the thousands split stays below one thousand
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (rem3_ff < THOUSAND))
      else $error("remainder out of range");

   // no steps means no calories and no distance
   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_daily_steps == 32'd0)) |->
      ((rsp_calories == 16'd0) && (rsp_distance == 32'd0)))
      else $error("metrics nonzero with zero steps");

endmodule

// ----- hw/rtl/step_counter_daily_accumulator.sv -----
`timescale 1ns / 1ps
// order: input register, update stage, metrics stages 2 to 5, then rsp_valid
// throughput: one request per cycle when not stalled, the six-stage pipeline fills
// bubbles under rsp_stall; the divide-by-thousand multiplier stages set the depth
// reset: synchronous, clears baseline, day, total and all stage valid bits
// reset: configuration returns to max delta 12, 40 kcal, 700 mm stride

module step_counter_daily_accumulator
   import scda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_hardware_step_count,
   input  logic                   req_date_read_ok,
   input  logic [6:0]             req_calendar_year,
   input  logic [3:0]             req_calendar_month,
   input  logic [4:0]             req_calendar_day,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_publish,
   output logic [31:0]            rsp_daily_steps,
   output logic [15:0]            rsp_calories,
   output logic [31:0]            rsp_distance,
   output logic                   rsp_metrics_valid,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type   cfg;
   logic      req_v_ff;
   poll_type  poll_ff;
   logic      rdy0;
   logic      upd_ready;
   logic      tally_valid;
   tally_type tally;
   logic      met_ready;

   scda_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // input register
   assign rdy0      = !req_v_ff || upd_ready;
   assign req_stall = !rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_v_ff <= 1'b0;
      end else if (rdy0) begin
         req_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_valid) begin
         poll_ff.count   <= req_hardware_step_count;
         poll_ff.date_ok <= req_date_read_ok;
         poll_ff.year    <= req_calendar_year;
         poll_ff.month   <= req_calendar_month;
         poll_ff.day     <= req_calendar_day;
      end
   end

   scda_update u_update (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_v_ff),
      .in_poll   (poll_ff),
      .in_ready  (upd_ready),
      .out_valid (tally_valid),
      .out_tally (tally),
      .out_ready (met_ready)
   );

   scda_metrics u_metrics (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (tally_valid),
      .in_tally          (tally),
      .in_ready          (met_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_publish       (rsp_publish),
      .rsp_daily_steps   (rsp_daily_steps),
      .rsp_calories      (rsp_calories),
      .rsp_distance      (rsp_distance),
      .rsp_metrics_valid (rsp_metrics_valid)
   );

endmodule
